>>> rtl/mctjm_pkg.sv
// Shared types, codes and constants of the MIDI clock tempo jitter meter.
package mctjm_pkg;

    // Operation codes of an input word
    localparam logic [2:0] OP_TICK    = 3'd0;
    localparam logic [2:0] OP_MIDI    = 3'd1;
    localparam logic [2:0] OP_REPORT  = 3'd2;
    localparam logic [2:0] OP_CLEAR   = 3'd3;
    localparam logic [2:0] OP_RESTART = 3'd4;

    // Configuration register indexes
    localparam logic REG_HOLD = 1'b0;
    localparam logic REG_RATE = 1'b1;

    // Result kinds
    localparam logic KIND_ECHO   = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam logic [7:0]  MIDI_CLOCK     = 8'hF8;
    localparam int          RATE_W         = 34;
    localparam logic [33:0] RATE_RESET     = 34'd5000000000;
    localparam logic [15:0] TEMPO_MAX      = 16'hFFFF;
    localparam logic [19:0] DEV_MAX        = 20'hFFFFF;
    localparam logic [19:0] DEV_HOLD_LIMIT = 20'd100000;
    localparam logic [19:0] DEV_OVER       = 20'd101000;
    localparam logic [17:0] DEV_SCALE      = 18'd200000;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] midi_byte;
    } in_word_t;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  thru_byte;
        logic        window_ready;
        logic [6:0]  slots_remaining;
        logic [15:0] average_tempo;
        logic [19:0] deviation;
        logic        over_range;
        logic        holding_max;
    } out_word_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_QST, ST_QWT, ST_QMUL, ST_ACC, ST_VAR1, ST_VAR2,
        ST_SQWT, ST_DMUL, ST_DST, ST_DWT, ST_FIN
    } state_t;

endpackage

>>> rtl/mctjm_ring.sv
// Interval ring: one write port, one registered read port.
module mctjm_ring #(
    parameter int DEPTH = 96,
    parameter int WIDTH = 24,
    parameter int AW    = 7
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

>>> rtl/mctjm_div.sv
// Restoring divider, one quotient bit per cycle.
module mctjm_div #(
    parameter int NUMW = 43,
    parameter int DENW = 24
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            start,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic            busy,
    output logic            done,
    output logic [NUMW-1:0] quot
);
    localparam int CW = $clog2(NUMW + 1);

    logic [NUMW-1:0] quot_reg, quot_next;
    logic [DENW-1:0] rem_reg, rem_next;
    logic [DENW-1:0] den_reg;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next, done_reg, done_next;
    logic [DENW:0]   rem_sh;

    // One shift-subtract step per cycle
    always_comb begin
        rem_sh    = {rem_reg, quot_reg[NUMW-1]};
        quot_next = quot_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            quot_next = num;
            rem_next  = '0;
            cnt_next  = CW'(NUMW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, den_reg}) begin
                rem_next  = DENW'(rem_sh - {1'b0, den_reg});
                quot_next = {quot_reg[NUMW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[DENW-1:0];
                quot_next = {quot_reg[NUMW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quot_reg <= quot_next;
        rem_reg  <= rem_next;
        if (start && !busy_reg) begin
            den_reg <= den;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;
endmodule

>>> rtl/mctjm_isqrt.sv
// Integer square root, one root bit per cycle.
module mctjm_isqrt #(
    parameter int VW = 48,
    parameter int RW = 24
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [VW-1:0] value,
    output logic          done,
    output logic [RW-1:0] root
);
    localparam int CW = $clog2(RW + 1);

    logic [2*RW-1:0] val_reg, val_next;
    logic [RW+2:0]   rem_reg, rem_next;
    logic [RW-1:0]   root_reg, root_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            busy_reg, busy_next, done_reg, done_next;
    logic [RW+2:0]   rem_sh, trial;

    // Bring down two bits, try appending a one to the root
    always_comb begin
        rem_sh    = {rem_reg[RW:0], val_reg[2*RW-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        val_next  = val_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start && !busy_reg) begin
            val_next  = (2*RW)'(value);
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CW'(RW);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            val_next = {val_reg[2*RW-3:0], 2'b00};
            if (rem_sh >= trial) begin
                rem_next  = rem_sh - trial;
                root_next = {root_reg[RW-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh;
                root_next = {root_reg[RW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        val_reg  <= val_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;
endmodule

>>> rtl/midi_clock_tempo_jitter_meter.sv
// Top level of the MIDI clock tempo jitter meter.
// Ticks, MIDI bytes, clear-max and restart words are handled in the cycle they
// are taken. An echo or an early report waits in a single output register, and
// no new word is taken while it waits unless it is being taken in that same
// cycle. A report that finds the ring full walks all WINDOW slots through one
// shared restoring divider (NUMW = 42 at defaults); a slot holding zero skips
// the divider. The walk then runs one square root (RW = 23) and, unless the
// tempo sum is zero, one more division. A report before the ring is full is
// answered in the cycle after it is taken. The ring is a single-port-write,
// registered-read memory.
module midi_clock_tempo_jitter_meter #(
    parameter int WINDOW     = 96,
    parameter int COUNT_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  mctjm_pkg::in_word_t  s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mctjm_pkg::out_word_t m_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [33:0]          cfg_data
);
    import mctjm_pkg::*;

    localparam int NW      = $clog2(WINDOW + 1);
    localparam int SLOT_W  = $clog2(WINDOW);
    localparam int SW      = 16 + NW;
    localparam int QW      = 32 + NW;
    localparam int VW      = QW + NW;
    localparam int RW      = (VW + 1) / 2;
    localparam int NUMD    = 19 + RW;
    localparam int NUMW    = (NUMD > RATE_W) ? NUMD : RATE_W;
    localparam int DENW    = ((SW + 1) > COUNT_BITS) ? (SW + 1) : COUNT_BITS;
    localparam int AVG_W   = SW + 2;
    localparam int AVG_DIV = 2 * WINDOW;
    // Rounded mean by reciprocal multiplication, exact for AVG_W-bit sums
    localparam int AVG_SH  = AVG_W + $clog2(AVG_DIV);
    localparam int AVG_MW  = AVG_W + 2;
    localparam int AVG_PW  = AVG_W + AVG_MW;
    localparam logic [AVG_MW-1:0] AVG_MUL =
        AVG_MW'(((64'd1 << AVG_SH) + 64'(AVG_DIV) - 64'd1) / 64'(AVG_DIV));

    state_t                state_reg, state_next;
    logic                  hold_reg;
    logic [RATE_W-1:0]     rate_reg;
    logic [COUNT_BITS-1:0] cnt_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic                  full_reg;
    logic [19:0]           maxdev_reg;
    logic [SLOT_W-1:0]     idx_reg;
    logic [15:0]           q_reg;
    logic [31:0]           sqp_reg;
    logic [SW-1:0]         s_reg;
    logic [QW-1:0]         sq_reg;
    logic [VW-1:0]         nsq_reg, ss_reg, var_reg;
    logic [RW-1:0]         r_reg;
    logic [NUMW-1:0]       num_reg;
    logic [19:0]           dev_reg;
    logic [15:0]           avg_reg;
    logic                  m_valid_reg;
    out_word_t             m_data_reg;

    logic                  accept;
    logic                  is_clock;
    logic [COUNT_BITS-1:0] ring_rdata;
    logic                  div_start, div_busy, div_done;
    logic [NUMW-1:0]       div_num, div_quot;
    logic [DENW-1:0]       div_den;
    logic                  sq_start, sq_done;
    logic [RW-1:0]         sq_root;
    logic [AVG_W-1:0]      avg_x;
    logic [AVG_PW-1:0]     avg_prod;
    logic [8:0]            slots_left;
    logic [19:0]           dev_out;
    logic                  max_upd;
    out_word_t             echo_word, idle_rep_word, fin_word;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign is_clock = accept && (s_data.operation == OP_MIDI) &&
                      (s_data.midi_byte == MIDI_CLOCK);

    // Interval storage
    mctjm_ring #(.DEPTH(WINDOW), .WIDTH(COUNT_BITS), .AW(SLOT_W)) u_ring (
        .aclk  (aclk),
        .we    (is_clock),
        .waddr (slot_reg),
        .wdata (cnt_reg),
        .raddr (idx_reg),
        .rdata (ring_rdata)
    );

    // Shared divider: tempo per slot, then the final deviation ratio
    assign div_start = ((state_reg == ST_QST) && (ring_rdata != '0)) ||
                       (state_reg == ST_DST);
    assign div_num   = (state_reg == ST_QST) ? NUMW'(rate_reg) : num_reg;
    assign div_den   = (state_reg == ST_QST) ? DENW'(ring_rdata)
                                             : DENW'({s_reg, 1'b0});

    mctjm_div #(.NUMW(NUMW), .DENW(DENW)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign sq_start = (state_reg == ST_VAR2);

    mctjm_isqrt #(.VW(VW), .RW(RW)) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sq_start),
        .value   ((nsq_reg > ss_reg) ? VW'(nsq_reg - ss_reg) : '0),
        .done    (sq_done),
        .root    (sq_root)
    );

    // Result words
    assign slots_left = 9'(WINDOW) - 9'(slot_reg);
    assign avg_x      = AVG_W'({s_reg, 1'b0}) + AVG_W'(WINDOW);
    assign avg_prod   = AVG_PW'(avg_x) * AVG_PW'(AVG_MUL);

    always_comb begin
        echo_word             = '0;
        echo_word.result_kind = KIND_ECHO;
        echo_word.thru_byte   = s_data.midi_byte;

        idle_rep_word                 = '0;
        idle_rep_word.result_kind     = KIND_REPORT;
        idle_rep_word.slots_remaining = slots_left[6:0];

        // Hold mode keeps the largest in-range deviation
        max_upd = 1'b0;
        dev_out = dev_reg;
        if (hold_reg && (dev_reg < DEV_HOLD_LIMIT)) begin
            if (dev_reg > maxdev_reg) begin
                max_upd = 1'b1;
            end else begin
                dev_out = maxdev_reg;
            end
        end
        fin_word               = '0;
        fin_word.result_kind   = KIND_REPORT;
        fin_word.window_ready  = 1'b1;
        fin_word.average_tempo = avg_reg;
        fin_word.deviation     = dev_out;
        fin_word.over_range    = (dev_out >= DEV_OVER);
        fin_word.holding_max   = hold_reg;
    end

    // Report sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && (s_data.operation == OP_REPORT) && full_reg) begin
                    state_next = ST_RD;
                end
            end
            ST_RD:   state_next = ST_QST;
            ST_QST:  state_next = (ring_rdata == '0) ? ST_QMUL : ST_QWT;
            ST_QWT: begin
                if (div_done) begin
                    state_next = ST_QMUL;
                end
            end
            ST_QMUL: state_next = ST_ACC;
            ST_ACC:  state_next = (idx_reg == SLOT_W'(WINDOW - 1)) ? ST_VAR1 : ST_RD;
            ST_VAR1: state_next = ST_VAR2;
            ST_VAR2: state_next = ST_SQWT;
            ST_SQWT: begin
                if (sq_done) begin
                    state_next = ST_DMUL;
                end
            end
            ST_DMUL: state_next = (s_reg == '0) ? ST_FIN : ST_DST;
            ST_DST:  state_next = ST_DWT;
            ST_DWT: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Control state and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_reg    <= 1'b0;
            rate_reg    <= RATE_RESET;
            cnt_reg     <= '0;
            slot_reg    <= '0;
            full_reg    <= 1'b0;
            maxdev_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    REG_HOLD: hold_reg <= cfg_data[0];
                    REG_RATE: rate_reg <= cfg_data;
                    default:  ;
                endcase
            end
            // Output register: loaded by an echo, an early report or a finished walk
            if ((accept && ((s_data.operation == OP_MIDI) ||
                            ((s_data.operation == OP_REPORT) && !full_reg))) ||
                (state_reg == ST_FIN)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (accept) begin
                case (s_data.operation)
                    OP_TICK: cnt_reg <= cnt_reg + 1'b1;
                    OP_MIDI: begin
                        if (is_clock) begin
                            cnt_reg <= '0;
                            if (slot_reg == SLOT_W'(WINDOW - 1)) begin
                                slot_reg <= '0;
                                full_reg <= 1'b1;
                            end else begin
                                slot_reg <= slot_reg + 1'b1;
                            end
                        end
                    end
                    OP_CLEAR: maxdev_reg <= '0;
                    OP_RESTART: begin
                        full_reg   <= 1'b0;
                        slot_reg   <= '0;
                        maxdev_reg <= '0;
                    end
                    default: ;
                endcase
            end
            if ((state_reg == ST_FIN) && max_upd) begin
                maxdev_reg <= dev_reg;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (accept && (s_data.operation == OP_MIDI)) begin
            m_data_reg <= echo_word;
        end else if (accept && (s_data.operation == OP_REPORT) && !full_reg) begin
            m_data_reg <= idle_rep_word;
        end else if (state_reg == ST_FIN) begin
            m_data_reg <= fin_word;
        end
        case (state_reg)
            ST_IDLE: begin
                idx_reg <= '0;
                s_reg   <= '0;
                sq_reg  <= '0;
                dev_reg <= '0;
            end
            ST_QST: q_reg <= TEMPO_MAX;
            ST_QWT: begin
                if (div_done) begin
                    q_reg <= (div_quot > NUMW'(TEMPO_MAX)) ? TEMPO_MAX : div_quot[15:0];
                end
            end
            ST_QMUL: sqp_reg <= q_reg * q_reg;
            ST_ACC: begin
                s_reg   <= s_reg + SW'(q_reg);
                sq_reg  <= sq_reg + QW'(sqp_reg);
                idx_reg <= idx_reg + 1'b1;
            end
            ST_VAR1: begin
                nsq_reg <= VW'(sq_reg) * VW'(WINDOW);
                ss_reg  <= VW'(s_reg) * VW'(s_reg);
                avg_reg <= 16'(avg_prod >> AVG_SH);
            end
            ST_VAR2: var_reg <= (nsq_reg > ss_reg) ? VW'(nsq_reg - ss_reg) : '0;
            ST_SQWT: begin
                if (sq_done) begin
                    r_reg <= sq_root;
                end
            end
            ST_DMUL: num_reg <= NUMW'(r_reg) * NUMW'(DEV_SCALE) + NUMW'(s_reg);
            ST_DWT: begin
                if (div_done) begin
                    dev_reg <= (div_quot > NUMW'(DEV_MAX)) ? DEV_MAX : div_quot[19:0];
                end
            end
            default: ;
        endcase
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // New words are blocked while the walk over the ring runs
    a_busy_no_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input taken during report");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= SLOT_W'(WINDOW - 1))
        else $error("write slot out of range");

    a_walk_needs_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RD) |-> full_reg)
        else $error("ring walk on unfilled ring");

    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_fin_output_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) |-> !m_valid_reg)
        else $error("report overwrites pending word");

    a_var_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQWT) |-> (var_reg <= nsq_reg))
        else $error("variance exceeds its minuend");
endmodule
